// ===== rtl/icsum_pkg.sv =====
// Types and constants shared by the streaming Internet checksum core.
// No dependencies; imported by icsum_accum and internet_checksum_stream_core.
package icsum_pkg;

   // pseudo-header mode codes held in the control register
   typedef enum logic [1:0] {
      MODE_PLAIN = 2'd0,
      MODE_UDP   = 2'd1,
      MODE_TCP   = 2'd2
   } mode_type;

   localparam logic [7:0]  PROTO_UDP    = 8'd17;
   localparam logic [7:0]  PROTO_TCP    = 8'd6;
   localparam logic [31:0] LEN_BIAS     = 32'd8;
   localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

   // finished buffer: unfolded 32-bit sum and the length flag
   typedef struct packed {
      logic [31:0] sum;
      logic        length_overflow;
   } total_type;

endpackage

// ===== rtl/icsum_accum.sv =====
// Stream state and word accumulation for the Internet checksum core.
// Depends on icsum_pkg; registers the unfolded total of each finished buffer.
module icsum_accum
   import icsum_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic        byte_valid,
   input  logic [7:0]  data_byte,
   input  logic        last_byte,
   input  logic [1:0]  mode,
   output logic        total_valid,
   output total_type   total
);

   logic [31:0] running_sum_ff, running_sum_in;
   logic [7:0]  held_high_ff, held_high_in;
   logic        odd_phase_ff, odd_phase_in;
   logic [15:0] byte_count_ff, byte_count_in;
   logic        overflowed_ff, overflowed_in;
   logic        total_valid_ff, total_valid_in;
   total_type   total_ff, total_in;

   logic [15:0] count_next;
   logic        overflow_next;
   logic [15:0] word;
   logic [31:0] term;
   logic [31:0] sum_with_word;

   // count bytes, flag a count past the 16-bit range
   assign count_next    = byte_count_ff + 16'd1;
   assign overflow_next = overflowed_ff | (byte_count_ff == COUNT_MAX);

   // pair bytes big-endian; a lone final byte is the high byte
   always_comb begin
      if (odd_phase_ff) begin
         word = {held_high_ff, data_byte};
      end else if (last_byte) begin
         word = {data_byte, 8'h00};
      end else begin
         word = 16'h0000;
      end
   end

   assign sum_with_word = running_sum_ff + {16'h0000, word};

   // pseudo-header terms: protocol plus the byte count less LEN_BIAS
   always_comb begin
      unique case (mode)
         MODE_UDP: term = {16'h0000, count_next} - LEN_BIAS + {24'h0, PROTO_UDP};
         MODE_TCP: term = {16'h0000, count_next} - LEN_BIAS + {24'h0, PROTO_TCP};
         default:  term = 32'h0000_0000;
      endcase
   end

   // advance stream state; clear it after the final byte
   always_comb begin
      running_sum_in = running_sum_ff;
      held_high_in   = held_high_ff;
      odd_phase_in   = odd_phase_ff;
      byte_count_in  = byte_count_ff;
      overflowed_in  = overflowed_ff;
      total_valid_in = total_valid_ff;
      total_in       = total_ff;
      if (advance) begin
         total_valid_in = byte_valid & last_byte;
         total_in.sum             = sum_with_word + term;
         total_in.length_overflow = overflow_next;
         if (byte_valid) begin
            if (last_byte) begin
               running_sum_in = 32'h0000_0000;
               held_high_in   = 8'h00;
               odd_phase_in   = 1'b0;
               byte_count_in  = 16'h0000;
               overflowed_in  = 1'b0;
            end else begin
               running_sum_in = sum_with_word;
               held_high_in   = odd_phase_ff ? held_high_ff : data_byte;
               odd_phase_in   = ~odd_phase_ff;
               byte_count_in  = count_next;
               overflowed_in  = overflow_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_sum_ff <= 32'h0000_0000;
         held_high_ff   <= 8'h00;
         odd_phase_ff   <= 1'b0;
         byte_count_ff  <= 16'h0000;
         overflowed_ff  <= 1'b0;
         total_valid_ff <= 1'b0;
      end else begin
         running_sum_ff <= running_sum_in;
         held_high_ff   <= held_high_in;
         odd_phase_ff   <= odd_phase_in;
         byte_count_ff  <= byte_count_in;
         overflowed_ff  <= overflowed_in;
         total_valid_ff <= total_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      total_ff <= total_in;
   end

   assign total_valid = total_valid_ff;
   assign total       = total_ff;

endmodule

// ===== rtl/internet_checksum_stream_core.sv =====
//  channel | direction | payload                                | handshake
//  req     | in        | data_byte[7:0], last_byte              | req_valid / req_stall
//  rsp     | out       | checksum_value[15:0], length_overflow  | rsp_valid / rsp_stall
//  csr     | in        | pseudo_header_mode[1:0]                | csr_wr_en
//
// One request per cycle while no stalled result holds the pipeline.
// The pipeline is request register, accumulator, fold and invert into the result register.
// A stalled result holds the whole pipeline; req_stall rises only then.
// Synchronous reset clears stream state, the mode register and all valids.
// Depends on icsum_pkg and icsum_accum.
module internet_checksum_stream_core
   import icsum_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_checksum_value,
   output logic        rsp_length_overflow,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_pseudo_header_mode
);

   logic [1:0]  mode_ff, mode_in;
   logic        req_valid_ff, req_valid_in;
   logic [7:0]  data_ff, data_in;
   logic        last_ff, last_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] checksum_ff, checksum_in;
   logic        overflow_ff, overflow_in;

   logic        advance;
   logic        total_valid;
   total_type   total;
   logic [16:0] fold_once;
   logic [15:0] fold_twice;

   // move every stage unless a result is stuck at the output
   assign advance   = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = ~advance;

   // load the mode register on csr_wr_en, else hold it
   always_comb begin
      mode_in = csr_wr_en ? csr_pseudo_header_mode : mode_ff;
   end

   // capture the request
   always_comb begin
      req_valid_in = req_valid_ff;
      data_in      = data_ff;
      last_in      = last_ff;
      if (advance) begin
         req_valid_in = req_valid;
         data_in      = req_data_byte;
         last_in      = req_last_byte;
      end
   end

   icsum_accum u_accum (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .byte_valid  (req_valid_ff),
      .data_byte   (data_ff),
      .last_byte   (last_ff),
      .mode        (mode_ff),
      .total_valid (total_valid),
      .total       (total)
   );

   // fold carries twice, which always lands in 16 bits, then invert
   assign fold_once  = {1'b0, total.sum[15:0]} + {1'b0, total.sum[31:16]};
   assign fold_twice = fold_once[15:0] + {15'h0000, fold_once[16]};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      checksum_in  = checksum_ff;
      overflow_in  = overflow_ff;
      if (advance) begin
         rsp_valid_in = total_valid;
         checksum_in  = ~fold_twice;
         overflow_in  = total.length_overflow;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_PLAIN;
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff     <= data_in;
      last_ff     <= last_in;
      checksum_ff <= checksum_in;
      overflow_ff <= overflow_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_checksum_value  = checksum_ff;
   assign rsp_length_overflow = overflow_ff;

endmodule

// ===== tb/checksum_result_checker.sv =====
`timescale 1ns / 100ps
// Result checker for internet_checksum_stream_core: tracks the mode register, recomputes
// the checksum of every request stream and compares each result in order.
// Depends on icsum_pkg.
module checksum_result_checker
   import icsum_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [15:0] rsp_checksum_value,
   input  logic        rsp_length_overflow,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_pseudo_header_mode,
   output int          error_count,
   output int          pending_count
);

   typedef struct packed {
      logic [15:0] checksum_value;
      logic        length_overflow;
   } checksum_result_type;

   checksum_result_type expected_checksums[$];

   // shadow of the mode register and of the stream state
   logic [1:0]  header_mode;
   logic [31:0] word_sum;
   logic [7:0]  high_byte;
   logic        low_byte_due;
   logic [15:0] stream_bytes;
   logic        stream_too_long;
   int          mismatches;

   initial begin
      mismatches = 0;
   end

   task automatic clear_stream();
      word_sum        = 32'h0000_0000;
      high_byte       = 8'h00;
      low_byte_due    = 1'b0;
      stream_bytes    = 16'h0000;
      stream_too_long = 1'b0;
   endtask

   // fold carries back into 16 bits, then take the ones-complement
   function automatic logic [15:0] fold_and_invert(input logic [31:0] total);
      logic [31:0] folded;
      folded = total;
      while (folded[31:16] != 16'h0000)
         folded = {16'h0000, folded[15:0]} + {16'h0000, folded[31:16]};
      return ~folded[15:0];
   endfunction

   // advance the stream by one byte; queue a checksum on the final byte
   task automatic predict_checksum(input logic [7:0] data, input logic last);
      logic [31:0]         total;
      checksum_result_type outcome;
      if (stream_bytes == COUNT_MAX)
         stream_too_long = 1'b1;
      stream_bytes = stream_bytes + 16'd1;

      if (low_byte_due) begin
         word_sum     = word_sum + {16'h0000, high_byte, data};
         low_byte_due = 1'b0;
      end else if (last) begin
         // lone trailing byte goes in the high half of the word
         word_sum = word_sum + {16'h0000, data, 8'h00};
      end else begin
         high_byte    = data;
         low_byte_due = 1'b1;
      end

      if (last) begin
         total = word_sum;
         if (header_mode == MODE_UDP)
            total = total + {24'h000000, PROTO_UDP} + {16'h0000, stream_bytes} - LEN_BIAS;
         else if (header_mode == MODE_TCP)
            total = total + {24'h000000, PROTO_TCP} + {16'h0000, stream_bytes} - LEN_BIAS;
         outcome.checksum_value  = fold_and_invert(total);
         outcome.length_overflow = stream_too_long;
         expected_checksums.push_back(outcome);
         clear_stream();
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] seen,
                                  input logic [31:0] wanted);
      $display("%0t checksum_result_checker: %s got %0h want %0h", $time, what, seen, wanted);
      mismatches++;
   endtask

   always @(posedge clock) begin
      checksum_result_type oldest;
      if (reset) begin
         header_mode = MODE_PLAIN;
         clear_stream();
         expected_checksums.delete();
      end else begin
         if (csr_wr_en)
            header_mode = csr_pseudo_header_mode;

         if (req_valid && !req_stall)
            predict_checksum(req_data_byte, req_last_byte);

         // compare each delivered result with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_checksums.size() == 0) begin
               report_mismatch("unexpected result checksum_value",
                               {16'h0000, rsp_checksum_value}, 32'h0);
            end else begin
               oldest = expected_checksums.pop_front();
               if (rsp_checksum_value !== oldest.checksum_value)
                  report_mismatch("checksum_value", {16'h0000, rsp_checksum_value},
                                  {16'h0000, oldest.checksum_value});
               if (rsp_length_overflow !== oldest.length_overflow)
                  report_mismatch("length_overflow", {31'h0, rsp_length_overflow},
                                  {31'h0, oldest.length_overflow});
            end
         end
      end
      error_count   <= mismatches;
      pending_count <= expected_checksums.size();
   end

endmodule

// ===== tb/tb_internet_checksum_stream_core.sv =====
`timescale 1ns / 100ps
// Top of the internet_checksum_stream_core testbench: clock, reset, request stimulus,
// result stalls, mode writes and the verdict. Depends on icsum_pkg and checksum_result_checker.
module tb_internet_checksum_stream_core;
   import icsum_pkg::*;

   localparam logic [1:0] MODE_SPARE     = 2'd3;
   localparam int         WATCHDOG_LIMIT = 4000;
   localparam int         SETTLE_CYCLES  = 8;
   localparam int         PHASE_BYTES    = 100;
   localparam int         PHASE_COUNT    = 8;

   typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_kind_type;

   logic        clock                  = 1'b0;
   logic        reset                  = 1'b1;
   logic        req_valid              = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte          = 8'h00;
   logic        req_last_byte          = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall              = 1'b0;
   logic [15:0] rsp_checksum_value;
   logic        rsp_length_overflow;
   logic        csr_wr_en              = 1'b0;
   logic [1:0]  csr_pseudo_header_mode = MODE_PLAIN;

   int error_count;
   int pending_count;
   int req_gap_max = 12;
   int rsp_gap_max = 12;
   int idle_cycles = 0;

   always #6 clock = ~clock;

   internet_checksum_stream_core dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_data_byte          (req_data_byte),
      .req_last_byte          (req_last_byte),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_checksum_value     (rsp_checksum_value),
      .rsp_length_overflow    (rsp_length_overflow),
      .csr_wr_en              (csr_wr_en),
      .csr_pseudo_header_mode (csr_pseudo_header_mode)
   );

   checksum_result_checker result_checker (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_data_byte          (req_data_byte),
      .req_last_byte          (req_last_byte),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_checksum_value     (rsp_checksum_value),
      .rsp_length_overflow    (rsp_length_overflow),
      .csr_wr_en              (csr_wr_en),
      .csr_pseudo_header_mode (csr_pseudo_header_mode),
      .error_count            (error_count),
      .pending_count          (pending_count)
   );

   // hold the result channel stalled for a random stretch before each result
   initial begin
      int hold;
      forever begin
         hold = $urandom_range(0, rsp_gap_max);
         if (hold > 0) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (hold - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // end the run when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("tb_internet_checksum_stream_core: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // drop valid for a random gap, then offer one request and wait until it is taken
   task automatic push_byte(input logic [7:0] data, input logic last);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      repeat (gap) begin
         @(negedge clock);
         req_valid     <= 1'b0;
         req_data_byte <= 8'($urandom);
         req_last_byte <= 1'($urandom);
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_data_byte <= data;
      req_last_byte <= last;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_packet(input int length, input fill_kind_type fill);
      logic [7:0] data;
      for (int i = 0; i < length; i++) begin
         case (fill)
            FILL_ONES:  data = 8'hFF;
            FILL_ZEROS: data = 8'h00;
            default:    data = 8'($urandom_range(0, 255));
         endcase
         push_byte(data, i == length - 1);
      end
   endtask

   // let every result drain and the pipeline settle before touching the register
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_mode(input logic [1:0] mode);
      wait_idle();
      @(negedge clock);
      csr_wr_en              <= 1'b1;
      csr_pseudo_header_mode <= mode;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int            phase_bytes;
      int            length;
      int            pick;
      fill_kind_type fill;
      logic [1:0]    phase_mode;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: plain mode straight from reset, lone trailing bytes, carries,
      // short streams whose length term wraps below zero, and the spare mode code
      send_packet(1, FILL_ONES);
      send_packet(2, FILL_ZEROS);
      send_packet(3, FILL_ONES);
      set_mode(MODE_UDP);
      send_packet(1, FILL_ZEROS);
      send_packet(8, FILL_ONES);
      set_mode(MODE_TCP);
      send_packet(2, FILL_RANDOM);
      send_packet(5, FILL_ONES);
      set_mode(MODE_SPARE);
      send_packet(3, FILL_RANDOM);

      // random packets in phases, each with its own mode and idling pattern
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0:       phase_mode = MODE_TCP;
            1:       phase_mode = MODE_UDP;
            2:       phase_mode = MODE_PLAIN;
            3:       phase_mode = MODE_SPARE;
            default: phase_mode = 2'($urandom_range(0, 3));
         endcase
         set_mode(phase_mode);
         if (phase == 0) begin
            req_gap_max = 12;
            rsp_gap_max = 12;
         end else if (phase == 1) begin
            req_gap_max = 0;
            rsp_gap_max = 0;
         end else begin
            req_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
            rsp_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
         end

         phase_bytes = 0;
         while (phase_bytes < PHASE_BYTES) begin
            pick = $urandom_range(0, 19);
            if (pick < 14)
               length = $urandom_range(1, 16);
            else if (pick < 19)
               length = $urandom_range(17, 64);
            else
               length = $urandom_range(65, 300);
            pick = $urandom_range(0, 15);
            if (pick == 0)
               fill = FILL_ZEROS;
            else if (pick < 3)
               fill = FILL_ONES;
            else
               fill = FILL_RANDOM;
            send_packet(length, fill);
            phase_bytes += length;
         end
      end

      wait_idle();
      if (error_count == 0)
         $display("tb_internet_checksum_stream_core: clean");
      else
         $display("tb_internet_checksum_stream_core: errors");
      $finish;
   end

endmodule
